FILE: src/rbol_pkg.sv
package rbol_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int HANDLE_W   = 32;
    localparam int SIZE_W     = 16;
    localparam int OFFSET_W   = 20;
    localparam int INDEX_W    = 4;
    localparam int ACC_W      = OFFSET_W + 1;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 72;

    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_FIND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    typedef struct packed {
        logic add;
        logic start;
        logic walk;
        logic load;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
    } t_dp_status;

endpackage

FILE: src/rbol_ctrl.sv
module rbol_ctrl
    import rbol_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic       i_opcode,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.add   = w_accept && (i_opcode == OP_ADD);
        o_cmd.start = w_accept && (i_opcode == OP_FIND);
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.start) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_status.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_find_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_WALK))
        else $error("find item did not start a walk");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (!r_out_valid || m_axis_tready))
        else $error("result loaded over a waiting item");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (m_axis_tvalid && r_state == ST_IDLE))
        else $error("loaded result not presented");

endmodule

FILE: src/rbol_dp.sv
module rbol_dp
    import rbol_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [HANDLE_W-1:0]   i_entry_handle,
    input  logic [SIZE_W-1:0]     i_entry_size,
    input  logic [OFFSET_W-1:0]   i_byte_offset,
    output logic                  o_found,
    output logic [INDEX_W-1:0]    o_slot_index,
    output logic [HANDLE_W-1:0]   o_found_handle,
    output logic [SIZE_W-1:0]     o_found_size,
    output logic [SIZE_W-1:0]     o_offset_in_entry
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int PW = (SW > INDEX_W) ? SW : INDEX_W;
    localparam logic [SW-1:0] LAST_SLOT  = SW'(SLOT_COUNT - 1);
    localparam logic [CW-1:0] SLOTS_FULL = CW'(SLOT_COUNT);

    logic [HANDLE_W-1:0] mem_handle [SLOT_COUNT];
    logic [SIZE_W-1:0]   mem_size   [SLOT_COUNT];

    logic [SW-1:0]       r_wr_slot;
    logic [SW-1:0]       r_rd_slot;
    logic                r_full;
    logic [SW-1:0]       r_pos;
    logic [CW-1:0]       r_left;
    logic [OFFSET_W-1:0] r_target;
    logic [ACC_W-1:0]    r_before;
    logic                r_chk_valid;
    logic [SW-1:0]       r_chk_pos;
    logic [HANDLE_W-1:0] r_rd_handle;
    logic [SIZE_W-1:0]   r_rd_size;

    logic                r_res_found;
    logic [INDEX_W-1:0]  r_res_index;
    logic [HANDLE_W-1:0] r_res_handle;
    logic [SIZE_W-1:0]   r_res_size;
    logic [SIZE_W-1:0]   r_res_offset;

    logic                r_out_found;
    logic [INDEX_W-1:0]  r_out_index;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [SIZE_W-1:0]   r_out_size;
    logic [SIZE_W-1:0]   r_out_offset;

    logic [SW-1:0]       n_wr_slot;
    logic [SW-1:0]       n_rd_slot;
    logic [CW-1:0]       n_count;
    logic [ACC_W-1:0]    n_after;
    logic [ACC_W-1:0]    n_delta;
    logic [PW-1:0]       n_pos_ext;
    logic                n_hit;
    logic                n_exhausted;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : s + SW'(1);
    endfunction

    always_comb begin
        n_wr_slot = next_slot(r_wr_slot);
        n_rd_slot = r_full ? next_slot(r_rd_slot) : r_rd_slot;
        if (r_full) begin
            n_count = SLOTS_FULL;
        end else if (r_wr_slot >= r_rd_slot) begin
            n_count = CW'(r_wr_slot) - CW'(r_rd_slot);
        end else begin
            n_count = SLOTS_FULL - CW'(r_rd_slot) + CW'(r_wr_slot);
        end
        n_after     = r_before + ACC_W'(r_rd_size);
        n_delta     = ACC_W'(r_target) - r_before;
        n_pos_ext   = PW'(r_chk_pos);
        n_hit       = r_chk_valid && (n_after > ACC_W'(r_target));
        n_exhausted = !r_chk_valid && (r_left == '0);
    end

    assign o_status.done = n_hit || n_exhausted;

    always_ff @(posedge i_clk) begin
        if (i_cmd.add) begin
            mem_handle[r_wr_slot] <= i_entry_handle;
            mem_size[r_wr_slot]   <= i_entry_size;
        end
        r_rd_handle <= mem_handle[r_pos];
        r_rd_size   <= mem_size[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_slot   <= '0;
            r_rd_slot   <= '0;
            r_full      <= 1'b0;
            r_left      <= '0;
            r_chk_valid <= 1'b0;
        end else begin
            if (i_cmd.add) begin
                r_wr_slot <= n_wr_slot;
                r_rd_slot <= n_rd_slot;
                r_full    <= r_full || (n_wr_slot == n_rd_slot);
            end
            if (i_cmd.start) begin
                r_left      <= n_count;
                r_chk_valid <= 1'b0;
            end else if (i_cmd.walk) begin
                if (r_left != '0) begin
                    r_left      <= r_left - CW'(1);
                    r_chk_valid <= 1'b1;
                end else begin
                    r_chk_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_pos    <= r_rd_slot;
            r_target <= i_byte_offset;
            r_before <= '0;
        end else if (i_cmd.walk) begin
            r_pos     <= next_slot(r_pos);
            r_chk_pos <= r_pos;
            if (r_chk_valid && !n_hit) begin
                r_before <= n_after;
            end
        end
        if (i_cmd.walk && n_hit) begin
            r_res_found  <= 1'b1;
            r_res_index  <= n_pos_ext[INDEX_W-1:0];
            r_res_handle <= r_rd_handle;
            r_res_size   <= r_rd_size;
            r_res_offset <= n_delta[SIZE_W-1:0];
        end else if (i_cmd.walk && n_exhausted) begin
            r_res_found  <= 1'b0;
            r_res_index  <= '0;
            r_res_handle <= '0;
            r_res_size   <= '0;
            r_res_offset <= '0;
        end
        if (i_cmd.load) begin
            r_out_found  <= r_res_found;
            r_out_index  <= r_res_index;
            r_out_handle <= r_res_handle;
            r_out_size   <= r_res_size;
            r_out_offset <= r_res_offset;
        end
    end

    assign o_found           = r_out_found;
    assign o_slot_index      = r_out_index;
    assign o_found_handle    = r_out_handle;
    assign o_found_size      = r_out_size;
    assign o_offset_in_entry = r_out_offset;

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= SLOTS_FULL)
        else $error("walk count beyond ring size");

    a_full_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && i_cmd.add) |=> (r_full && r_wr_slot == r_rd_slot))
        else $error("full ring lost its full state on add");

    a_sum_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.walk && r_chk_valid) |-> (r_before <= ACC_W'(r_target)))
        else $error("running sum passed the target without a hit");

endmodule

FILE: src/ring_buffer_offset_lookup.sv
// Channel   Dir  Item                 tdata (low bit up)                          tuser
// s_axis    in   add or find request  entry_handle, entry_size, byte_offset, pad  opcode
// m_axis    out  find result          slot_index, found_handle, found_size,       found
//                                     offset_in_entry, pad
//
// An add gives no result item.
// A find walks the occupied slots from the oldest and stops at the first hit or after the
// last occupied slot: one slot read a cycle from the slot memory, whose registered read
// port paces the walk.
// i_rst_n (synchronous, active low) empties the ring at once; no clearing pass.
// A find result waits in the output register while further items are taken; a further find
// then holds its result, and the input, until the waiting item leaves.
module ring_buffer_offset_lookup
    import rbol_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // entry_handle, entry_size, byte_offset
    input  logic [0:0]            s_axis_tuser,  // opcode
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,  // slot_index, found_handle, found_size,
                                                 // offset_in_entry
    output logic [0:0]            m_axis_tuser   // found
);

    localparam int SIZE_LO = HANDLE_W;
    localparam int OFFS_LO = HANDLE_W + SIZE_W;
    localparam int OUT_USED = INDEX_W + HANDLE_W + SIZE_W + SIZE_W;

    t_dp_cmd             w_cmd;
    t_dp_status          w_status;
    logic                w_found;
    logic [INDEX_W-1:0]  w_slot_index;
    logic [HANDLE_W-1:0] w_found_handle;
    logic [SIZE_W-1:0]   w_found_size;
    logic [SIZE_W-1:0]   w_offset_in_entry;

    rbol_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_opcode      (s_axis_tuser[0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    rbol_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_entry_handle    (s_axis_tdata[HANDLE_W-1:0]),
        .i_entry_size      (s_axis_tdata[SIZE_LO +: SIZE_W]),
        .i_byte_offset     (s_axis_tdata[OFFS_LO +: OFFSET_W]),
        .o_found           (w_found),
        .o_slot_index      (w_slot_index),
        .o_found_handle    (w_found_handle),
        .o_found_size      (w_found_size),
        .o_offset_in_entry (w_offset_in_entry)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - OUT_USED){1'b0}}, w_offset_in_entry, w_found_size,
                           w_found_handle, w_slot_index};
    assign m_axis_tuser = w_found;

endmodule
